[sv/mpt_pkg.sv]
// ----------------------------------------------------------------------------
// Mesh path table package
// Sizes, codes and the command and status types shared by the table's parts.
// ----------------------------------------------------------------------------
package mpt_pkg;

  // Number of table entries (1 to 1024).
  localparam int unsigned ENTRIES  = 32;
  localparam int unsigned IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W    = $clog2(ENTRIES + 1);
  localparam int unsigned MAC_W    = 48;
  localparam int unsigned METRIC_W = 64;

  typedef enum logic {
    FUNC_LEARN = 1'b0,
    FUNC_ROUTE = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_NOROUTE = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_e;

  // One stored table entry.
  typedef struct packed {
    logic [MAC_W-1:0]    dest;
    logic [MAC_W-1:0]    hop;
    logic [METRIC_W-1:0] metric;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture a new item and restart the scan
    logic issue;      // read the entry at the scan pointer
    logic hit_latch;  // remember the entry that matched
    logic finish;     // update the table and present the result
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hit;        // the entry read last cycle holds the destination
    logic pending;    // a read is in flight
    logic issue_done; // every filled entry has been read
  } dp_status_t;

endpackage

[sv/mesh_path_table_top.sv]
// ----------------------------------------------------------------------------
// Mesh path table
// Fixed-capacity path table keyed by destination MAC, with learn and lookup.
// ----------------------------------------------------------------------------
// An item is taken at a rising edge where start is high and busy is low, and
// exactly one result follows: result_valid_o is high for a single cycle while
// status_o and next_hop_o carry it, and the receiver cannot stall it, so it
// must take the result in that cycle. A learn item (func_i low) stores the
// offered next hop and metric if the destination is new and a free entry
// remains, replaces them if the destination is held and the offered metric is
// strictly smaller, and otherwise leaves the table alone; it reports table
// full only when a new destination finds no room. A lookup item (func_i high)
// returns the stored next hop, or reports no route with next_hop_o at zero.
// Entries are filled in order and are never removed, so a fill count stands
// in for per-entry valid flags and no clearing pass is needed after reset.
// The entries live in a single RAM with one read port, scanned one entry per
// cycle up to the fill count, stopping early at a match. After acceptance an
// item keeps busy high through its scan and the final update, so a new item
// is accepted only once the last one is finished. The result strobe appears
// in the first cycle in which busy is low again, and a new item may be
// started in that same cycle.
// ----------------------------------------------------------------------------
module mesh_path_table_top
  import mpt_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic                func_i,
  input  logic [MAC_W-1:0]    dest_mac_i,
  input  logic [MAC_W-1:0]    hop_mac_i,
  input  logic [METRIC_W-1:0] path_metric_i,
  output logic                result_valid_o,
  output logic [1:0]          status_o,
  output logic [MAC_W-1:0]    next_hop_o
);

  ctrl_cmd_t  cmd;
  dp_status_t dp_status;

  // The controller decides when to capture, scan, stop and update.
  mpt_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .busy_o   (busy),
    .status_i (dp_status),
    .cmd_o    (cmd)
  );

  // The datapath holds the item, the table memory and the result registers.
  mpt_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (dp_status),
    .func_i         (func_i),
    .dest_mac_i     (dest_mac_i),
    .hop_mac_i      (hop_mac_i),
    .path_metric_i  (path_metric_i),
    .result_valid_o (result_valid_o),
    .status_res_o   (status_o),
    .next_hop_o     (next_hop_o)
  );

endmodule

[sv/mpt_ram.sv]
// ----------------------------------------------------------------------------
// Mesh path table RAM
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module mpt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/mpt_ctrl.sv]
// ----------------------------------------------------------------------------
// Mesh path table controller
// Sequences the capture of an item, the entry scan and the final update.
// ----------------------------------------------------------------------------
module mpt_ctrl
  import mpt_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        // Stop at the first match, or once every filled entry has been compared.
        if (status_i.hit) begin
          cmd_o.hit_latch = 1'b1;
          state_d         = S_FINISH;
        end else if (status_i.issue_done && !status_i.pending) begin
          state_d = S_FINISH;
        end else if (!status_i.issue_done) begin
          cmd_o.issue = 1'b1;
        end
      end
      S_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

[sv/mpt_dp.sv]
// ----------------------------------------------------------------------------
// Mesh path table datapath
// Item registers, entry memory, scan pointer, fill count and result registers.
// ----------------------------------------------------------------------------
module mpt_dp
  import mpt_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ctrl_cmd_t           cmd_i,
  output dp_status_t          status_o,
  input  logic                func_i,
  input  logic [MAC_W-1:0]    dest_mac_i,
  input  logic [MAC_W-1:0]    hop_mac_i,
  input  logic [METRIC_W-1:0] path_metric_i,
  output logic                result_valid_o,
  output logic [1:0]          status_res_o,
  output logic [MAC_W-1:0]    next_hop_o
);

  // Captured item.
  logic                func_q;
  logic [MAC_W-1:0]    dest_q;
  logic [MAC_W-1:0]    hop_q;
  logic [METRIC_W-1:0] metric_q;

  // Scan state. Entries are filled in order and never removed, so the
  // filled entries are always exactly those below the fill count.
  logic [CNT_W-1:0] count_q;
  logic [CNT_W-1:0] scan_q;
  logic             rd_vld_q;
  logic [IDX_W-1:0] cmp_idx_q;
  logic             hit_q;
  logic [IDX_W-1:0] hit_idx_q;

  // Result registers.
  logic             res_vld_q;
  status_e          res_status_q;
  logic [MAC_W-1:0] res_hop_q;

  entry_t           rd_entry;
  entry_t           wr_entry;
  logic             we;
  logic [IDX_W-1:0] waddr;
  logic             table_full;
  logic             better;
  status_e          res_status_d;
  logic [MAC_W-1:0] res_hop_d;

  mpt_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wr_entry),
    .re_i    (cmd_i.issue),
    .raddr_i (scan_q[IDX_W-1:0]),
    .rdata_o (rd_entry)
  );

  assign status_o.hit        = rd_vld_q && (rd_entry.dest == dest_q);
  assign status_o.pending    = rd_vld_q;
  assign status_o.issue_done = (scan_q == count_q);

  assign table_full = (count_q == CNT_W'(ENTRIES));
  assign better     = (metric_q < rd_entry.metric);

  assign wr_entry.dest   = dest_q;
  assign wr_entry.hop    = hop_q;
  assign wr_entry.metric = metric_q;

  always_comb begin
    we           = 1'b0;
    waddr        = hit_idx_q;
    res_status_d = ST_OK;
    res_hop_d    = '0;
    if (func_q == FUNC_LEARN) begin
      if (hit_q) begin
        // The read data still holds the matched entry.
        we = cmd_i.finish && better;
      end else if (table_full) begin
        res_status_d = ST_FULL;
      end else begin
        we    = cmd_i.finish;
        waddr = count_q[IDX_W-1:0];
      end
    end else begin
      if (hit_q) begin
        res_hop_d = rd_entry.hop;
      end else begin
        res_status_d = ST_NOROUTE;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q   <= func_i;
      dest_q   <= dest_mac_i;
      hop_q    <= hop_mac_i;
      metric_q <= path_metric_i;
    end
    cmp_idx_q <= scan_q[IDX_W-1:0];
    if (cmd_i.hit_latch) begin
      hit_idx_q <= cmp_idx_q;
    end
    if (cmd_i.finish) begin
      res_status_q <= res_status_d;
      res_hop_q    <= res_hop_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      scan_q    <= '0;
      rd_vld_q  <= 1'b0;
      hit_q     <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      res_vld_q <= cmd_i.finish;
      if (cmd_i.load) begin
        scan_q   <= '0;
        rd_vld_q <= 1'b0;
        hit_q    <= 1'b0;
      end else begin
        rd_vld_q <= cmd_i.issue;
        if (cmd_i.issue) begin
          scan_q <= scan_q + CNT_W'(1);
        end
        if (cmd_i.hit_latch) begin
          hit_q <= 1'b1;
        end
      end
      if (cmd_i.finish && (func_q == FUNC_LEARN) && !hit_q && !table_full) begin
        count_q <= count_q + CNT_W'(1);
      end
    end
  end

  assign result_valid_o = res_vld_q;
  assign status_res_o   = res_status_q;
  assign next_hop_o     = res_hop_q;

endmodule

[sv/mpt_checker.sv]
// ----------------------------------------------------------------------------
// Mesh path table checker
// Port-level assertions on the item and result timing and the result codes.
// ----------------------------------------------------------------------------
module mpt_checker
  import mpt_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start,
  input logic                busy,
  input logic                result_valid_o,
  input logic [1:0]          status_o,
  input logic [MAC_W-1:0]    next_hop_o
);

  // An accepted item keeps the block occupied in the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted item did not make the block busy");

  // The block only goes idle by delivering the result of its item.
  a_idle_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> result_valid_o)
    else $error("block went idle without a result");

  // A result is a single-cycle strobe shown while the block is idle.
  a_strobe_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy ##1 !result_valid_o)
    else $error("result strobe malformed");

  // Only a successful lookup carries a next hop; codes stay in range.
  a_hop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (status_o != ST_OK) |-> (next_hop_o == '0) &&
    ((status_o == ST_FULL) || (status_o == ST_NOROUTE)))
    else $error("failed item carried a next hop or a bad status");

endmodule

bind mesh_path_table_top mpt_checker u_mpt_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .status_o       (status_o),
  .next_hop_o     (next_hop_o)
);
